// ===== src/lhb_pkg.sv =====
// Shared package for the lowercase djb2 base-36 hash block.
// Holds the hash constants, character codes, back-end state type and helpers.
// No dependencies; every other source file imports it.
`timescale 1ns / 1ps
`default_nettype none

package lhb_pkg;

    // Hash and conversion constants.
    localparam logic [31:0] LHB_HASH_SEED  = 32'd5381;
    // ceil(2^33 / 9): exact quotient of a 30-bit value by 9 after a 33-bit shift.
    localparam logic [29:0] LHB_RECIP_9    = 30'd954437177;
    localparam int          LHB_RECIP_SHIFT = 33;
    localparam int          LHB_DIGITS     = 7;
    localparam int          LHB_DIGIT_W    = 6;
    localparam int          LHB_CNT_W      = 3;
    localparam int          LHB_FIFO_DEPTH = 2;

    // Text characters.
    localparam logic [6:0] LHB_CHAR_S     = 7'h73;
    localparam logic [6:0] LHB_CHAR_COLON = 7'h3A;
    localparam logic [6:0] LHB_CHAR_ZERO  = 7'h30;
    localparam logic [6:0] LHB_CHAR_ALPHA = 7'h57;

    // One finished hash moving from the front end through the queue.
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } lhb_hash_xfer_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_EMIT_S,
        BK_EMIT_COLON,
        BK_EMIT_DIGIT
    } lhb_back_state_t;

    // Map ASCII upper case letters to lower case; other bytes pass unchanged.
    function automatic logic [7:0] lhb_fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Base-36 digit to its ASCII character: 0-9 then a-z.
    function automatic logic [6:0] lhb_digit_char(input logic [LHB_DIGIT_W-1:0] d);
        logic [6:0] r;
        if (d < LHB_DIGIT_W'(10))
        begin
            r = LHB_CHAR_ZERO + {1'b0, d};
        end
        else
        begin
            r = LHB_CHAR_ALPHA + {1'b0, d};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lowercase_djb2_base36_hash.sv =====
// Top level of the lowercase djb2 hash with base-36 text output.
// Instantiates lhb_front, lhb_fifo and lhb_back; depends on lhb_pkg.
//
//   Channel  | Direction | tdata                          | tuser         | tlast
//   s_axis   | in        | byte_value[7:0]                | byte_present  | string_end
//   m_axis   | out       | text_char[6:0], hash_word[38:7] | -            | text_last
//
// The front end hashes string bytes at full stream rate.
// Each string end queues its hash; the back end takes it, then finds each base-36
// digit with a multiply state and a divide state in its shared reciprocal multiplier
// (up to 7 digits), then emits the text characters (3 to 9) while the output slot drains.
// The input stalls only while the hash queue is full; the output register lets
// the back end take the next hash while the final character waits.
// Reset is asynchronous and active low; it clears all control and reseeds the hash.
`timescale 1ns / 1ps
`default_nettype none

module lowercase_djb2_base36_hash #(
    parameter int FIFO_DEPTH = lhb_pkg::LHB_FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [6:0] text_char, [38:7] hash_word, [39] zero
    output logic             m_axis_tlast
);
    import lhb_pkg::*;

    lhb_hash_xfer_t push;
    lhb_hash_xfer_t pop;
    logic           queue_full;
    logic           pop_ready;
    logic [6:0]     text_char;
    logic [31:0]    hash_word;

    // Byte intake and hashing.
    lhb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .byte_value   (s_axis_tdata),
        .byte_present (s_axis_tuser[0]),
        .string_end   (s_axis_tlast),
        .queue_full   (queue_full),
        .push         (push)
    );

    // Queue of finished hashes.
    lhb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // Base-36 conversion and text emission.
    lhb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .text_char (text_char),
        .text_last (m_axis_tlast),
        .hash_word (hash_word)
    );

    assign m_axis_tdata = {1'b0, hash_word, text_char};

endmodule

`default_nettype wire

// ===== src/lhb_front.sv =====
// Front end: accepts string bytes, lowercases them and runs the djb2 hash.
// Pushes each finished hash into the queue. Depends on lhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhb_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              byte_value,
    input  wire logic                    byte_present,
    input  wire logic                    string_end,
    input  wire logic                    queue_full,
    output lhb_pkg::lhb_hash_xfer_t      push
);
    import lhb_pkg::*;

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] hash_calc;
    logic        accept;

    // Every transfer waits while the hash queue is full.
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // h * 33 + c as a shift and two adds.
    always_comb
    begin
        if (byte_present)
        begin
            hash_calc = {hash_reg[26:0], 5'b0} + hash_reg
                        + {24'b0, lhb_fold_case(byte_value)};
        end
        else
        begin
            hash_calc = hash_reg;
        end
    end

    // The accumulator reseeds after each string end.
    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = string_end ? LHB_HASH_SEED : hash_calc;
        end
    end

    assign push.valid = accept && string_end;
    assign push.hash  = hash_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= LHB_HASH_SEED;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lhb_fifo.sv =====
// Short queue of finished hashes between the front end and the back end.
// Register-based, first in first out. Depends on lhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhb_fifo #(
    parameter int DEPTH = lhb_pkg::LHB_FIFO_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lhb_pkg::lhb_hash_xfer_t push,
    output logic                         full,
    output lhb_pkg::lhb_hash_xfer_t      pop,
    input  wire logic                    pop_ready
);
    import lhb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [31:0]      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop.valid = (count_reg != '0);
    assign pop.hash  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop.valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.hash;
        end
    end

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && full))
        else $error("hash pushed into a full queue");

    a_count_track : assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fill count did not follow a lone push");
`endif

endmodule

`default_nettype wire

// ===== src/lhb_back.sv =====
// Back end: converts a finished hash to base-36 digits and emits "s:" plus digits.
// One digit per multiply and divide state pair through a reciprocal multiplier. Depends on lhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhb_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lhb_pkg::lhb_hash_xfer_t pop,
    output logic                         pop_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [6:0]                   text_char,
    output logic                         text_last,
    output logic [31:0]                  hash_word
);
    import lhb_pkg::*;

    lhb_back_state_t            state_reg;
    lhb_back_state_t            state_next;

    logic [31:0]                hash_reg;
    logic [31:0]                hash_next;
    logic [31:0]                value_reg;
    logic [31:0]                value_next;
    logic [59:0]                prod_reg;
    logic [59:0]                prod_next;
    logic [LHB_CNT_W-1:0]       digit_count_reg;
    logic [LHB_CNT_W-1:0]       digit_count_next;
    logic [LHB_CNT_W-1:0]       emit_ptr_reg;
    logic [LHB_CNT_W-1:0]       emit_ptr_next;
    logic [LHB_DIGIT_W-1:0]     digit_store [LHB_DIGITS];

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [6:0]                 out_char_reg;
    logic [6:0]                 out_char_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic [31:0]                out_hash_reg;
    logic [31:0]                out_hash_next;

    logic                       slot_free;
    logic                       load_out;
    logic                       digit_we;
    logic [LHB_CNT_W-1:0]       digit_addr;
    logic [LHB_DIGIT_W-1:0]     digit_wdata;
    logic [26:0]                quot;
    logic [31:0]                quot_x36;
    logic [31:0]                remain;

    // The output slot can take a new character when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Quotient by 36 from the registered product, and the remainder.
    assign quot     = prod_reg[59:LHB_RECIP_SHIFT];
    assign quot_x36 = {quot, 5'b0} + {3'b0, quot, 2'b0};
    assign remain   = value_reg - quot_x36;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop.valid)
                begin
                    state_next = (pop.hash == '0) ? BK_EMIT_S : BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                state_next = (quot == '0) ? BK_EMIT_S : BK_MUL;
            end
            BK_EMIT_S:
            begin
                if (slot_free)
                begin
                    state_next = BK_EMIT_COLON;
                end
            end
            BK_EMIT_COLON:
            begin
                if (slot_free)
                begin
                    state_next = BK_EMIT_DIGIT;
                end
            end
            BK_EMIT_DIGIT:
            begin
                if (slot_free && (emit_ptr_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and output control per state.
    always_comb
    begin
        pop_ready        = 1'b0;
        hash_next        = hash_reg;
        value_next       = value_reg;
        prod_next        = prod_reg;
        digit_count_next = digit_count_reg;
        emit_ptr_next    = emit_ptr_reg;
        digit_we         = 1'b0;
        digit_addr       = digit_count_reg;
        digit_wdata      = remain[LHB_DIGIT_W-1:0];
        load_out         = 1'b0;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_hash_next    = out_hash_reg;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready        = 1'b1;
                if (pop.valid)
                begin
                    hash_next        = pop.hash;
                    value_next       = pop.hash;
                    digit_count_next = '0;
                    // A zero hash is written as a single zero digit.
                    if (pop.hash == '0)
                    begin
                        digit_we         = 1'b1;
                        digit_addr       = '0;
                        digit_wdata      = '0;
                        digit_count_next = LHB_CNT_W'(1);
                    end
                end
            end
            BK_MUL:
            begin
                prod_next = value_reg[31:2] * LHB_RECIP_9;
            end
            BK_DIV:
            begin
                digit_we         = 1'b1;
                digit_count_next = digit_count_reg + 1'b1;
                value_next       = {5'b0, quot};
            end
            BK_EMIT_S:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    out_char_next = LHB_CHAR_S;
                    out_last_next = 1'b0;
                    out_hash_next = hash_reg;
                end
            end
            BK_EMIT_COLON:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    out_char_next = LHB_CHAR_COLON;
                    out_last_next = 1'b0;
                    out_hash_next = hash_reg;
                    emit_ptr_next = digit_count_reg - 1'b1;
                end
            end
            BK_EMIT_DIGIT:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    out_char_next = lhb_digit_char(digit_store[emit_ptr_reg]);
                    out_last_next = (emit_ptr_reg == '0);
                    out_hash_next = hash_reg;
                    emit_ptr_next = emit_ptr_reg - 1'b1;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            digit_count_reg <= '0;
            emit_ptr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            emit_ptr_reg    <= emit_ptr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        value_reg    <= value_next;
        prod_reg     <= prod_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_hash_reg <= out_hash_next;
    end

    // Digit store, least significant digit first.
    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digit_store[digit_addr] <= digit_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = out_char_reg;
    assign text_last = out_last_reg;
    assign hash_word = out_hash_reg;

`ifndef SYNTHESIS
    a_div_exact : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> ((quot_x36 <= value_reg) && (remain < 32'd36)))
        else $error("reciprocal quotient by 36 is off");

    a_digits_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT_DIGIT) |-> ((digit_count_reg != '0)
            && (emit_ptr_reg < digit_count_reg)))
        else $error("digit emission outside the converted digits");

    a_last_is_digit : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
            (((out_char_reg >= 7'h30) && (out_char_reg <= 7'h39))
            || ((out_char_reg >= 7'h61) && (out_char_reg <= 7'h7A))))
        else $error("final character is not a base-36 digit");
`endif

endmodule

`default_nettype wire

// ===== tb/hash_text_checker.sv =====
// Checker for the lowercase djb2 base-36 hash block: watches both stream channels,
// predicts the "s:" hash text of every finished string and compares each character.
// Depends on lhb_pkg for the hash seed and the text prefix characters.
`timescale 1ns / 1ps

module hash_text_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // [6:0] text_char, [38:7] hash_word, [39] zero
    input  wire logic        m_axis_tlast,
    output int               text_pending,
    output int               mismatch_count
);
    import lhb_pkg::*;

    localparam logic [6:0] DIGIT_BASE  = 7'h30;   // '0'
    localparam logic [6:0] LETTER_BASE = 7'h61;   // 'a'

    // One expected character of the hash text.
    typedef struct {
        logic [6:0]  ch;
        logic        last;
        logic [31:0] hash;
    } text_beat_t;

    logic [31:0] running_hash;
    text_beat_t  expected_text[$];

    // Append "s:" and the base-36 digits of a finished hash, most significant first.
    function automatic void queue_hash_text(input logic [31:0] h);
        logic [5:0]  digit [LHB_DIGITS];
        logic [31:0] v;
        int          n;
        text_beat_t  beat;
        v = h;
        n = 0;
        if (v == 32'd0)
        begin
            digit[0] = 6'd0;
            n = 1;
        end
        while (v != 32'd0)
        begin
            digit[n] = 6'(v % 32'd36);
            v = v / 32'd36;
            n++;
        end
        beat.hash = h;
        beat.last = 1'b0;
        beat.ch = LHB_CHAR_S;
        expected_text.push_back(beat);
        beat.ch = LHB_CHAR_COLON;
        expected_text.push_back(beat);
        for (int i = n - 1; i >= 0; i--)
        begin
            if (digit[i] < 6'd10)
                beat.ch = DIGIT_BASE + {1'b0, digit[i]};
            else
                beat.ch = LETTER_BASE + {1'b0, digit[i]} - 7'd10;
            beat.last = (i == 0);
            expected_text.push_back(beat);
        end
    endfunction

    // Hash the accepted bytes and check every accepted text character.
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [7:0] folded;
        text_beat_t beat;
        if (!rst_n)
        begin
            running_hash = LHB_HASH_SEED;
            expected_text.delete();
            mismatch_count = 0;
            text_pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                begin
                    // Upper case ASCII letters hash as their lower case form.
                    folded = s_axis_tdata;
                    if (folded >= 8'h41 && folded <= 8'h5A)
                        folded = folded + 8'h20;
                    running_hash = running_hash * 32'd33 + {24'd0, folded};
                end
                if (s_axis_tlast)
                begin
                    queue_hash_text(running_hash);
                    running_hash = LHB_HASH_SEED;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected text character %h with no string finished",
                           m_axis_tdata[6:0]);
                    mismatch_count++;
                end
                else
                begin
                    beat = expected_text.pop_front();
                    if (m_axis_tdata[6:0] !== beat.ch)
                    begin
                        $error("text_char: expected %h, got %h", beat.ch, m_axis_tdata[6:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== beat.last)
                    begin
                        $error("text_last: expected %b, got %b", beat.last, m_axis_tlast);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[38:7] !== beat.hash)
                    begin
                        $error("hash_word: expected %h, got %h", beat.hash,
                               m_axis_tdata[38:7]);
                        mismatch_count++;
                    end
                end
            end
            text_pending <= expected_text.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the lowercase djb2 base-36 hash block: clock, reset,
// string stimulus with random sender gaps and receiver stalls, and the verdict.
// Depends on lhb_pkg, lowercase_djb2_base36_hash and hash_text_checker.
`timescale 1ns / 1ps

module tb;
    import lhb_pkg::*;

    localparam int ITEM_TARGET   = 100;
    localparam int QUIET_FROM    = 80;
    localparam int SETTLE_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [39:0] m_axis_tdata;
    wire         m_axis_tlast;

    int text_pending;
    int mismatch_count;
    int bytes_and_ends = 0;
    bit quiet = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lowercase_djb2_base36_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hash_text_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .text_pending   (text_pending),
        .mismatch_count (mismatch_count)
    );

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver pacing: stretches that are calm or busy, with random receiver stalls.
    initial
    begin : sink_pacing
        int stall_left;
        int stretch_left;
        int busy_odds;
        stall_left = 0;
        stretch_left = 0;
        busy_odds = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 100);
                busy_odds = $urandom_range(0, 2);
            end
            stretch_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && busy_odds != 0 && $urandom_range(0, 4 * busy_odds) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one input item and hold it until the transfer, then maybe leave a gap.
    task automatic send_item(input logic [7:0] value, input logic present, input logic ending);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= present;
        s_axis_tlast <= ending;
        do @(posedge clk); while (!s_axis_tready);
        if (present || ending)
            bytes_and_ends++;
        if (bytes_and_ends >= QUIET_FROM)
            quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Hold the input back until every predicted character has come out.
    task automatic wait_for_text();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (text_pending != 0);
    endtask

    // Seven bytes in 0..32 chosen so that the string hashes exactly to the target.
    task automatic send_string_to_hash(input logic [31:0] target);
        logic [31:0]     lead;
        logic [31:0]     diff;
        longint unsigned rest;
        logic [7:0]      part [7];
        lead = LHB_HASH_SEED;
        repeat (7) lead = lead * 32'd33;
        diff = target - lead;
        rest = diff;
        for (int i = 6; i >= 0; i--)
        begin
            part[i] = 8'(rest % 33);
            rest = rest / 33;
        end
        for (int i = 0; i < 7; i++)
            send_item(part[i], 1'b1, i == 6);
    endtask

    // A string of random length and letter mix, ended on its last byte or after it.
    task automatic send_random_string();
        int         len;
        int         style;
        int         pick;
        logic       end_on_byte;
        logic [7:0] b;
        len = $urandom_range(0, 10);
        style = $urandom_range(0, 3);
        end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            pick = (style == 3) ? $urandom_range(0, 2) : style;
            case (pick)
                0: b = 8'($urandom_range(8'h41, 8'h5A));
                1: b = 8'($urandom_range(8'h61, 8'h7A));
                default: b = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(b, 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty string, then an idle item that must change nothing.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        // Letter boundaries, zero and all-ones bytes, and a byte on the end item.
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h40, 1'b1, 1'b0);
        send_item(8'h5B, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b1);
        // A zero hash prints one digit; the largest hash prints seven.
        send_string_to_hash(32'h0000_0000);
        send_string_to_hash(32'hFFFF_FFFF);
        wait_for_text();

        // Random strings, short-text hashes and idle items.
        while (bytes_and_ends < ITEM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0: send_string_to_hash(32'($urandom_range(0, 1295)));
                1: send_string_to_hash($urandom);
                2: send_item(8'($urandom), 1'b0, 1'b0);
                default: send_random_string();
            endcase
            if (!quiet && $urandom_range(0, 19) == 0)
                wait_for_text();
        end

        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
